// ===== src/rse_pkg.sv =====
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants
// Widths, limits and the queue entry type between front and back.
// ----------------------------------------------------------------------------
package rse_pkg;
   localparam int MaxBins = 256;
   localparam int CountW = $clog2(MaxBins + 1);
   localparam int MagW = 16;
   localparam int TotalW = 24;
   localparam int WeightW = 44;
   localparam int OutW = 20;
   localparam int LogW = 21;
   localparam int OutMin = -524288;
   localparam int QDepth = 4;
   localparam int QPtrW = $clog2(QDepth);

   typedef struct packed {
      logic [MagW-1:0] mag;
      logic            acc;
      logic            ovf;
      logic            last;
   } entry_type;
endpackage

// ===== src/rse_log2.sv =====
// ----------------------------------------------------------------------------
// rse_log2: iterative Q.16 log2
// Takes an operand of up to 24 bits and produces its log2 with 16 fraction
// bits, one fraction bit per squaring step.
// ----------------------------------------------------------------------------
module rse_log2 (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [rse_pkg::TotalW-1:0] operand,
   output logic                   done,
   output logic [rse_pkg::LogW-1:0] result
);
   import rse_pkg::*;

   logic [31:0] y_ff, y_in;
   logic [4:0]  e_ff, e_in;
   logic [15:0] frac_ff, frac_in;
   logic [4:0]  step_ff, step_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] sq;
   logic [31:0] ys;
   logic [4:0]  msb;

   always_comb begin
      msb = 5'd0;
      for (int i = 0; i < TotalW; i++) begin
         if (operand[i]) begin
            msb = 5'(i);
         end
      end
   end

   assign sq = 64'(y_ff) * 64'(y_ff);
   assign ys = sq[61:30];

   always_comb begin
      y_in = y_ff;
      e_in = e_ff;
      frac_in = frac_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start && !busy_ff) begin
         y_in = 32'(operand) << (5'd30 - msb);
         e_in = (operand == '0) ? 5'd0 : msb;
         frac_in = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ys[31]) begin
            y_in = ys >> 1;
         end else begin
            y_in = ys;
         end
         frac_in = {frac_ff[14:0], ys[31]};
         step_in = step_ff + 5'd1;
         if (step_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      y_ff <= y_in;
      e_ff <= e_in;
      frac_ff <= frac_in;
      step_ff <= step_in;
   end

   assign done = done_ff;
   assign result = {e_ff, frac_ff};
endmodule

// ===== src/rse_front.sv =====
// ----------------------------------------------------------------------------
// rse_front: bin classifier
// Marks each bin as DC, accumulated or overflow and pushes it to the queue.
// ----------------------------------------------------------------------------
module rse_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic [rse_pkg::MagW-1:0] magnitude,
   input  logic                 last_in_row,
   input  logic                 q_full,
   output logic                 q_push,
   output rse_pkg::entry_type   q_data
);
   import rse_pkg::*;

   logic              start_ff, start_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              take;

   assign full = q_full;
   assign take = push && !q_full;

   always_comb begin
      start_in = start_ff;
      count_in = count_ff;
      q_data.mag = magnitude;
      q_data.last = last_in_row;
      q_data.acc = 1'b0;
      q_data.ovf = 1'b0;
      if (!start_ff) begin
         if (count_ff >= CountW'(MaxBins)) begin
            q_data.ovf = 1'b1;
         end else begin
            q_data.acc = 1'b1;
         end
      end
      if (take) begin
         start_in = last_in_row;
         if (last_in_row) begin
            count_in = '0;
         end else if (!start_ff && count_ff < CountW'(MaxBins)) begin
            count_in = count_ff + CountW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         count_ff <= '0;
      end else begin
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   assign q_push = take;
endmodule

// ===== src/rse_back.sv =====
// ----------------------------------------------------------------------------
// rse_back: accumulator and row finisher
// Accumulates S and W per bin using the log2 unit, then divides W by S
// bit-serially and subtracts log2 S at the end of a row.
// ----------------------------------------------------------------------------
module rse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  rse_pkg::entry_type   q_data,
   output logic                 out_valid,
   input  logic                 out_take,
   output logic signed [rse_pkg::OutW-1:0] neg_entropy,
   output logic                 zero_total,
   output logic                 too_many_bins
);
   import rse_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_LOG  = 7'b0000010,
      S_MAC  = 7'b0000100,
      S_DIV  = 7'b0001000,
      S_SLOG = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [TotalW-1:0]   tot_ff, tot_in;
   logic [WeightW-1:0]  w_ff, w_in;
   logic                ovf_ff, ovf_in;
   entry_type           cur_ff, cur_in;
   logic [WeightW-1:0]  quo_ff, quo_in;
   logic [TotalW:0]     rem_ff, rem_in;
   logic [5:0]          dstep_ff, dstep_in;
   logic signed [OutW-1:0] res_ff, res_in;
   logic                zero_ff, zero_in;
   logic                lstart;
   logic [TotalW-1:0]   lop;
   logic                ldone;
   logic [LogW-1:0]     lres;
   logic [TotalW:0]     trial;
   logic [MagW+LogW-1:0] prod;
   logic [WeightW+1:0]  wsum;
   logic [TotalW:0]     tsum;
   logic signed [WeightW+1:0] r;

   rse_log2 u_log2 (
      .clock(clock), .reset(reset), .start(lstart), .operand(lop),
      .done(ldone), .result(lres)
   );

   assign trial = {rem_ff[TotalW-1:0], w_ff[6'(WeightW-1) - dstep_ff]};
   assign prod = cur_ff.mag * lres;
   assign wsum = (WeightW+2)'(w_ff) + (WeightW+2)'(prod);
   assign tsum = (TotalW+1)'(tot_ff) + (TotalW+1)'(cur_ff.mag);
   assign r = $signed((WeightW+2)'(quo_ff)) - $signed((WeightW+2)'(lres));

   always_comb begin
      state_in = state_ff;
      tot_in = tot_ff;
      w_in = w_ff;
      ovf_in = ovf_ff;
      cur_in = cur_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      dstep_in = dstep_ff;
      res_in = res_ff;
      zero_in = zero_ff;
      q_pop = 1'b0;
      lstart = 1'b0;
      lop = (state_ff == S_IDLE) ? TotalW'(q_data.mag) : tot_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               cur_in = q_data;
               if (q_data.ovf) begin
                  ovf_in = 1'b1;
               end
               if (q_data.acc) begin
                  lstart = 1'b1;
                  state_in = S_LOG;
               end else if (q_data.last) begin
                  state_in = S_DIV;
               end
               dstep_in = '0;
               quo_in = '0;
               rem_in = '0;
            end
         end
         S_LOG: begin
            if (ldone) begin
               state_in = S_MAC;
            end
         end
         S_MAC: begin
            w_in = (wsum > (WeightW+2)'({WeightW{1'b1}})) ? '1 : wsum[WeightW-1:0];
            tot_in = tsum[TotalW] ? '1 : tsum[TotalW-1:0];
            state_in = cur_ff.last ? S_DIV : S_IDLE;
         end
         S_DIV: begin
            if (trial >= (TotalW+1)'(tot_ff)) begin
               rem_in = trial - (TotalW+1)'(tot_ff);
               quo_in = {quo_ff[WeightW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[WeightW-2:0], 1'b0};
            end
            dstep_in = dstep_ff + 6'd1;
            if (tot_ff == '0) begin
               state_in = S_FIN;
            end else if (dstep_ff == 6'(WeightW-1)) begin
               lstart = 1'b1;
               state_in = S_SLOG;
            end
         end
         S_SLOG: begin
            if (ldone) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            zero_in = (tot_ff == '0);
            if (tot_ff == '0 || r > 0) begin
               res_in = '0;
            end else if (r < (WeightW+2)'(OutMin)) begin
               res_in = OutW'(OutMin);
            end else begin
               res_in = r[OutW-1:0];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_take) begin
               tot_in = '0;
               w_in = '0;
               ovf_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         tot_ff <= '0;
         w_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tot_ff <= tot_in;
         w_ff <= w_in;
         ovf_ff <= ovf_in;
      end
      cur_ff <= cur_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dstep_ff <= dstep_in;
      res_ff <= res_in;
      zero_ff <= zero_in;
   end

   assign out_valid = (state_ff == S_OUT);
   assign neg_entropy = res_ff;
   assign zero_total = zero_ff;
   assign too_many_bins = ovf_ff;
endmodule

// ===== src/rse_queue.sv =====
// ----------------------------------------------------------------------------
// rse_queue: classified bin queue
// A short first-in first-out store between the front and the back.
// ----------------------------------------------------------------------------
module rse_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rse_pkg::entry_type wdata,
   output logic               full,
   input  logic               pop,
   output rse_pkg::entry_type rdata,
   output logic               empty
);
   import rse_pkg::*;

   entry_type        mem_ff [QDepth];
   logic [QPtrW-1:0] wp_ff, rp_ff;
   logic [QPtrW:0]   cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + QPtrW'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + QPtrW'(1);
         end
         cnt_ff <= cnt_ff + (QPtrW+1)'(push) - (QPtrW+1)'(pop);
      end
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
   end

   assign rdata = mem_ff[rp_ff];
   assign full = (cnt_ff == (QPtrW+1)'(QDepth));
   assign empty = (cnt_ff == '0);
endmodule

// ===== src/row_spectral_entropy.sv =====
// ----------------------------------------------------------------------------
// row_spectral_entropy: negative spectral entropy of one spectrum row
// Streams bin magnitudes in and gives one Q4.16 result per row.
// ----------------------------------------------------------------------------
// Input beats carry one bin magnitude and a last_in_row flag; push is taken
// whenever full is low. The first bin of each row is the DC bin and is
// skipped. A four-entry queue decouples the classifier from the accumulator.
// Each accumulated bin holds the back end while the shared log2 unit, which
// squares once per fraction bit, works on it; DC and overflow bins do not
// use the log2 unit. At the end of a row the bit-serial divider runs, then
// the final log2 and the finish step; a row whose total is zero cuts the
// divide short and skips the log2. One result waits on the rsp_ ports while
// empty is low; while the receiver stalls the back end holds and the queue
// fills, then full rises. Reset clears all row state and the queue; the next
// bin after reset is a DC bin.
// ----------------------------------------------------------------------------
module row_spectral_entropy (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [rse_pkg::MagW-1:0]   req_magnitude,
   input  logic                       req_last_in_row,
   output logic                       empty,
   input  logic                       pop,
   output logic signed [rse_pkg::OutW-1:0] rsp_neg_entropy,
   output logic                       rsp_zero_total,
   output logic                       rsp_too_many_bins
);
   import rse_pkg::*;

   entry_type qin, qout;
   logic q_push, q_full, q_pop, q_empty, out_valid;

   rse_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .magnitude(req_magnitude), .last_in_row(req_last_in_row),
      .q_full(q_full), .q_push(q_push), .q_data(qin)
   );

   rse_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .wdata(qin), .full(q_full),
      .pop(q_pop), .rdata(qout), .empty(q_empty)
   );

   rse_back u_back (
      .clock(clock), .reset(reset), .q_empty(q_empty), .q_pop(q_pop),
      .q_data(qout), .out_valid(out_valid), .out_take(pop && out_valid),
      .neg_entropy(rsp_neg_entropy), .zero_total(rsp_zero_total),
      .too_many_bins(rsp_too_many_bins)
   );

   assign empty = !out_valid;

   a_pos: assert property (@(posedge clock) disable iff (reset)
      !empty |-> rsp_neg_entropy <= 0) else $error("result above zero");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_zero_total) |-> rsp_neg_entropy == 0)
      else $error("zero total with nonzero result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty) else $error("result dropped");
endmodule
